### rtl/core/scrollback_line_ring_wrap_macros.svh
// assertion macros for the scrollback line ring
// used by the top level only, no other dependencies
`ifndef SCROLLBACK_LINE_RING_WRAP_MACROS_SVH
`define SCROLLBACK_LINE_RING_WRAP_MACROS_SVH

// same-cycle implication
`define SLRW_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// next-cycle implication
`define SLRW_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

### rtl/core/slrw_pkg.sv
// types, constants and helpers for the scrollback line ring
// no dependencies
package slrw_pkg;

  localparam int unsigned WINDOWS     = 11;
  localparam int unsigned STORE_DEPTH = 179520;
  localparam int unsigned STAGE_DEPTH = 79;

  localparam logic [3:0] WINDOWS_W4    = 4'd11;
  localparam logic [7:0] RING_SLOTS    = 8'd204;
  localparam logic [8:0] RING_SLOTS_W9 = 9'd204;
  localparam logic [6:0] SLOT_LAST     = 7'd79;
  localparam logic [6:0] WRAP_COLS     = 7'd78;
  localparam logic [6:0] COPY_END      = 7'd80;
  localparam logic [7:0] VIEW_ROWS     = 8'd20;
  localparam logic [4:0] VIEW_ROWS_W5  = 5'd20;
  localparam logic [4:0] BOTTOM_ROW    = 5'd19;
  localparam logic [7:0] PAGE_STEP     = 8'd19;
  localparam logic [7:0] SPACE         = 8'd32;
  localparam logic [11:0] SLOT_MULT    = 12'd204;
  localparam logic [17:0] BYTE_MULT    = 18'd80;

  localparam logic [2:0] ACT_OPEN  = 3'd0;
  localparam logic [2:0] ACT_CLOSE = 3'd1;
  localparam logic [2:0] ACT_CHAR  = 3'd2;
  localparam logic [2:0] ACT_END   = 3'd3;
  localparam logic [2:0] ACT_UP    = 3'd4;
  localparam logic [2:0] ACT_DOWN  = 3'd5;
  localparam logic [2:0] ACT_READ  = 3'd6;

  localparam logic [1:0] KIND_CHUNK = 2'd0;
  localparam logic [1:0] KIND_VIEW  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] window;
    logic [7:0] char_code;
    logic       show_live;
    logic       storage_ok;
    logic [4:0] row;
    logic [6:0] column;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       stored;
    logic [7:0] slot_index;
    logic       draw_live;
    logic       scroll_first;
    logic [4:0] draw_row;
    logic       is_live;
    logic [7:0] view_top;
    logic [7:0] line_count;
    logic [7:0] read_byte;
  } result_t;

  function automatic logic [7:0] top_of(input logic live, input logic [7:0] lines,
                                         input logic [7:0] view);
    logic [7:0] top;
    if (live) begin
      top = (lines > VIEW_ROWS) ? lines - VIEW_ROWS : 8'd0;
    end else begin
      top = view;
    end
    return top;
  endfunction

endpackage

### rtl/core/slrw_front.sv
// front end: accepts items, drops ignored ones, queues the rest
// depends on slrw_pkg
module slrw_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  slrw_pkg::item_t item,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output slrw_pkg::item_t cmd
);

  slrw_pkg::item_t q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       keep;
  logic       push;
  logic       pop;

  assign keep = (item.window < slrw_pkg::WINDOWS_W4) && (item.action <= slrw_pkg::ACT_READ) &&
                !((item.action == slrw_pkg::ACT_CHAR) && (item.char_code == 8'd0));
  assign item_ready = (count != 2'd2);
  assign push = item_valid && item_ready && keep;
  assign cmd_valid = (count != 2'd0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### rtl/core/slrw_back.sv
// back end: window state, staging buffer, line store and result register
// depends on slrw_pkg
module slrw_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  slrw_pkg::item_t   cmd,
  output logic              result_valid,
  input  logic              result_ready,
  output slrw_pkg::result_t result
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_PUT    = 4'd2;
  localparam logic [3:0] S_ADDR1  = 4'd3;
  localparam logic [3:0] S_ADDR2  = 4'd4;
  localparam logic [3:0] S_COPY   = 4'd5;
  localparam logic [3:0] S_SHIFT  = 4'd6;
  localparam logic [3:0] S_RSLOT  = 4'd7;
  localparam logic [3:0] S_RMEM   = 4'd8;
  localparam logic [3:0] S_RESULT = 4'd9;

  logic [3:0] state;
  slrw_pkg::item_t cur;

  logic       has_storage  [slrw_pkg::WINDOWS];
  logic [7:0] stored_lines [slrw_pkg::WINDOWS];
  logic [7:0] oldest_slot  [slrw_pkg::WINDOWS];
  logic       live_mode    [slrw_pkg::WINDOWS];
  logic [7:0] view_line    [slrw_pkg::WINDOWS];
  logic [4:0] rows_shown   [slrw_pkg::WINDOWS];

  logic [6:0] stage_length;
  logic       after_cut;
  logic [6:0] last_space;

  logic [6:0]  chunk_len;
  logic [6:0]  brk;
  logic        is_cut;
  logic [1:0]  r_kind;
  logic        r_stored;
  logic [7:0]  r_slot;
  logic        r_draw;
  logic        r_scroll;
  logic [4:0]  r_drow;
  logic [8:0]  rd_li;
  logic        rd_hit;
  logic [11:0] wslot;
  logic [17:0] base;
  logic [6:0]  cnt;
  logic [6:0]  src;
  logic [6:0]  dst;
  logic        p_valid;
  logic        skipping;

  logic [7:0] stage_mem [slrw_pkg::STAGE_DEPTH];
  logic [7:0] stage_q;
  logic       stage_we;
  logic [6:0] stage_wa;
  logic [7:0] stage_wd;
  logic [6:0] stage_ra;

  logic [7:0]  text_mem [slrw_pkg::STORE_DEPTH];
  logic [7:0]  text_q;
  logic        text_we;
  logic [17:0] text_wa;
  logic [7:0]  text_wd;
  logic        text_re;

  logic [3:0] w;
  logic       char_drop;
  logic [6:0] brk_sel;
  logic [7:0] cur_top;
  logic [7:0] scroll_v;
  logic [8:0] scroll_sum;
  logic [8:0] put_sum;
  logic [8:0] rd_sum;
  logic       consume_keep;
  logic [6:0] copy_idx;

  assign w = cur.window;
  assign cmd_ready = (state == S_IDLE);
  assign cur_top = slrw_pkg::top_of(live_mode[w], stored_lines[w], view_line[w]);
  assign char_drop = (cur.char_code == slrw_pkg::SPACE) && after_cut && (stage_length == 7'd0);
  assign brk_sel = (cur.char_code == slrw_pkg::SPACE) ? slrw_pkg::WRAP_COLS :
                   ((last_space != 7'd0) ? last_space : slrw_pkg::WRAP_COLS);
  assign scroll_v = live_mode[w] ? stored_lines[w] - slrw_pkg::VIEW_ROWS : view_line[w];
  assign scroll_sum = {1'b0, scroll_v} + {1'b0, slrw_pkg::PAGE_STEP};
  assign put_sum = {1'b0, oldest_slot[w]} + {1'b0, stored_lines[w]};
  assign rd_sum = {1'b0, oldest_slot[w]} + {1'b0, rd_li[7:0]};
  assign consume_keep = !(skipping && (stage_q == slrw_pkg::SPACE));
  assign copy_idx = cnt - 7'd1;

  always_comb begin
    stage_we = 1'b0;
    stage_wa = stage_length;
    stage_wd = cur.char_code;
    stage_ra = 7'd0;
    text_we  = 1'b0;
    text_wa  = base + {11'd0, copy_idx};
    text_wd  = (copy_idx < chunk_len) ? stage_q : 8'd0;
    text_re  = 1'b0;
    case (state)
      S_EXEC: begin
        stage_we = (cur.action == slrw_pkg::ACT_CHAR) && !char_drop;
      end
      S_COPY: begin
        stage_ra = (cnt < slrw_pkg::SLOT_LAST) ? cnt : 7'd0;
        text_we  = (cnt != 7'd0);
      end
      S_SHIFT: begin
        stage_ra = (src < slrw_pkg::SLOT_LAST) ? src : 7'd0;
        stage_we = p_valid && consume_keep;
        stage_wa = dst;
        stage_wd = stage_q;
      end
      S_RMEM: begin
        text_re = 1'b1;
      end
      default: begin
        stage_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stage_we) begin
      stage_mem[stage_wa] <= stage_wd;
    end
    stage_q <= stage_mem[stage_ra];
  end

  always_ff @(posedge clk) begin
    if (text_we) begin
      text_mem[text_wa] <= text_wd;
    end
    if (text_re) begin
      text_q <= text_mem[base];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stage_length <= 7'd0;
      after_cut    <= 1'b0;
      last_space   <= 7'd0;
      result_valid <= 1'b0;
      for (int i = 0; i < slrw_pkg::WINDOWS; i++) begin
        has_storage[i]  <= 1'b0;
        stored_lines[i] <= 8'd0;
        oldest_slot[i]  <= 8'd0;
        live_mode[i]    <= 1'b1;
        view_line[i]    <= 8'd0;
        rows_shown[i]   <= 5'd0;
      end
    end else begin
      if (result_valid && result_ready && (state != S_RESULT)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur      <= cmd;
            r_stored <= 1'b0;
            r_slot   <= 8'd0;
            r_draw   <= 1'b0;
            r_scroll <= 1'b0;
            r_drow   <= 5'd0;
            rd_hit   <= 1'b0;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cur.action)
            slrw_pkg::ACT_OPEN: begin
              has_storage[w]  <= cur.storage_ok;
              stored_lines[w] <= 8'd0;
              oldest_slot[w]  <= 8'd0;
              live_mode[w]    <= 1'b1;
              view_line[w]    <= 8'd0;
              rows_shown[w]   <= 5'd0;
              r_kind          <= slrw_pkg::KIND_VIEW;
              state           <= S_RESULT;
            end
            slrw_pkg::ACT_CLOSE: begin
              has_storage[w]  <= 1'b0;
              stored_lines[w] <= 8'd0;
              oldest_slot[w]  <= 8'd0;
              live_mode[w]    <= 1'b1;
              view_line[w]    <= 8'd0;
              state           <= S_IDLE;
            end
            slrw_pkg::ACT_CHAR: begin
              if (char_drop) begin
                state <= S_IDLE;
              end else if (stage_length == slrw_pkg::WRAP_COLS) begin
                chunk_len <= brk_sel;
                brk       <= brk_sel;
                is_cut    <= 1'b1;
                after_cut <= 1'b1;
                r_kind    <= slrw_pkg::KIND_CHUNK;
                state     <= S_PUT;
              end else begin
                stage_length <= stage_length + 7'd1;
                if ((cur.char_code == slrw_pkg::SPACE) && (stage_length != 7'd0)) begin
                  last_space <= stage_length;
                end
                state <= S_IDLE;
              end
            end
            slrw_pkg::ACT_END: begin
              stage_length <= 7'd0;
              last_space   <= 7'd0;
              after_cut    <= 1'b0;
              if ((stage_length == 7'd0) && after_cut) begin
                state <= S_IDLE;
              end else begin
                chunk_len <= stage_length;
                is_cut    <= 1'b0;
                r_kind    <= slrw_pkg::KIND_CHUNK;
                state     <= S_PUT;
              end
            end
            slrw_pkg::ACT_UP, slrw_pkg::ACT_DOWN: begin
              if (has_storage[w] && (stored_lines[w] > slrw_pkg::VIEW_ROWS)) begin
                rows_shown[w] <= slrw_pkg::VIEW_ROWS_W5;
                if (cur.action == slrw_pkg::ACT_UP) begin
                  view_line[w] <= (scroll_v >= slrw_pkg::PAGE_STEP) ?
                                  scroll_v - slrw_pkg::PAGE_STEP : 8'd0;
                  live_mode[w] <= 1'b0;
                end else if (scroll_sum >= {1'b0, stored_lines[w] - slrw_pkg::VIEW_ROWS}) begin
                  live_mode[w] <= 1'b1;
                  view_line[w] <= 8'd0;
                end else begin
                  view_line[w] <= scroll_sum[7:0];
                end
              end
              r_kind <= slrw_pkg::KIND_VIEW;
              state  <= S_RESULT;
            end
            default: begin
              rd_li  <= {1'b0, cur_top} + {4'd0, cur.row};
              rd_hit <= has_storage[w] && (cur.row < slrw_pkg::VIEW_ROWS_W5) &&
                        (({1'b0, cur_top} + {4'd0, cur.row}) < {1'b0, stored_lines[w]});
              r_kind <= slrw_pkg::KIND_READ;
              state  <= S_RSLOT;
            end
          endcase
        end
        S_PUT: begin
          if (has_storage[w]) begin
            r_stored <= 1'b1;
            if (stored_lines[w] < slrw_pkg::RING_SLOTS) begin
              r_slot <= (put_sum >= slrw_pkg::RING_SLOTS_W9) ?
                        8'(put_sum - slrw_pkg::RING_SLOTS_W9) : put_sum[7:0];
              stored_lines[w] <= stored_lines[w] + 8'd1;
            end else begin
              r_slot <= oldest_slot[w];
              oldest_slot[w] <= (oldest_slot[w] == slrw_pkg::RING_SLOTS - 8'd1) ?
                                8'd0 : oldest_slot[w] + 8'd1;
            end
          end
          if (cur.show_live && live_mode[w]) begin
            r_draw <= 1'b1;
            if (rows_shown[w] < slrw_pkg::VIEW_ROWS_W5) begin
              r_drow <= rows_shown[w];
              rows_shown[w] <= rows_shown[w] + 5'd1;
            end else begin
              r_scroll <= 1'b1;
              r_drow   <= slrw_pkg::BOTTOM_ROW;
            end
          end
          cnt        <= 7'd0;
          src        <= brk;
          dst        <= 7'd0;
          p_valid    <= 1'b0;
          skipping   <= 1'b1;
          if (has_storage[w]) begin
            state <= S_ADDR1;
          end else if (is_cut) begin
            last_space <= 7'd0;
            state      <= S_SHIFT;
          end else begin
            state <= S_RESULT;
          end
        end
        S_ADDR1: begin
          wslot <= 12'({8'd0, w} * slrw_pkg::SLOT_MULT) + {4'd0, r_slot};
          state <= S_ADDR2;
        end
        S_ADDR2: begin
          if (cur.action == slrw_pkg::ACT_READ) begin
            base  <= 18'({6'd0, wslot} * slrw_pkg::BYTE_MULT) +
                     ((cur.column < slrw_pkg::SLOT_LAST) ? {11'd0, cur.column} : 18'd0);
            state <= S_RMEM;
          end else begin
            base  <= 18'({6'd0, wslot} * slrw_pkg::BYTE_MULT);
            state <= S_COPY;
          end
        end
        S_COPY: begin
          if (cnt == slrw_pkg::COPY_END) begin
            if (is_cut) begin
              last_space <= 7'd0;
              state      <= S_SHIFT;
            end else begin
              state <= S_RESULT;
            end
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_SHIFT: begin
          if (src < slrw_pkg::SLOT_LAST) begin
            src     <= src + 7'd1;
            p_valid <= 1'b1;
          end else begin
            p_valid <= 1'b0;
          end
          if (p_valid && consume_keep) begin
            skipping <= 1'b0;
            dst      <= dst + 7'd1;
            if ((dst != 7'd0) && (stage_q == slrw_pkg::SPACE)) begin
              last_space <= dst;
            end
          end
          if ((src == slrw_pkg::SLOT_LAST) && !p_valid) begin
            stage_length <= dst;
            state        <= S_RESULT;
          end
        end
        S_RSLOT: begin
          if (rd_hit) begin
            r_slot <= (rd_sum >= slrw_pkg::RING_SLOTS_W9) ?
                      8'(rd_sum - slrw_pkg::RING_SLOTS_W9) : rd_sum[7:0];
            state  <= S_ADDR1;
          end else begin
            state <= S_RESULT;
          end
        end
        S_RMEM: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!result_valid || result_ready) begin
            result.kind         <= r_kind;
            result.stored       <= r_stored;
            result.slot_index   <= r_slot;
            result.draw_live    <= r_draw;
            result.scroll_first <= r_scroll;
            result.draw_row     <= r_drow;
            result.is_live      <= live_mode[w];
            result.view_top     <= cur_top;
            result.line_count   <= stored_lines[w];
            result.read_byte    <= (rd_hit && (cur.column < slrw_pkg::SLOT_LAST)) ?
                                   text_q : 8'd0;
            result_valid        <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/scrollback_line_ring_wrap.sv
// Per-window text scrollback with word wrap. Items enter a two-deep queue and are
// carried out one at a time by a sequencer. Open and page moves give a result; a close, a
// character that is only staged or dropped, or a line end with nothing staged after a cut
// frees the sequencer with no result. A read gives a result; when the row holds a line it
// first forms the slot and byte address and reads the line store. A finished chunk gives a
// result; with storage it first does slot address arithmetic and an 80-byte slot copy,
// one byte per cycle through the single byte-wide write port of the line store. After a
// wrap cut the leftover is moved down in the staging buffer one byte per cycle. A result
// not yet taken holds the sequencer. The line store is not cleared at reset: slots are
// read only after written.
module scrollback_line_ring_wrap (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  slrw_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output slrw_pkg::result_t result
);

  `include "scrollback_line_ring_wrap_macros.svh"

  logic            cmd_valid;
  logic            cmd_ready;
  slrw_pkg::item_t cmd;

  slrw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  slrw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  `SLRW_ASSERT_NOW(a_unstored_slot, clk, rst,
    result_valid && (result.kind == slrw_pkg::KIND_CHUNK) && !result.stored,
    result.slot_index == 8'd0, "unstored chunk reports a slot")
  `SLRW_ASSERT_NOW(a_draw_chunk_only, clk, rst,
    result_valid && (result.kind != slrw_pkg::KIND_CHUNK),
    !result.draw_live && !result.scroll_first, "draw flags outside a chunk")
  `SLRW_ASSERT_NOW(a_view_in_range, clk, rst, result_valid,
    result.view_top <= result.line_count, "view top beyond stored lines")

endmodule

### tb/tb_top.sv
// self-checking testbench for scrollback_line_ring_wrap: directed and random words
// are predicted by a behavioral copy of the scrollback and compared field by field
// depends on slrw_pkg and the scrollback_line_ring_wrap rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NWIN      = 11;
  localparam int NSLOTS    = 204;
  localparam int NBYTES    = 80;
  localparam int WRAP      = 78;
  localparam int NROWS     = 20;
  localparam int LIMIT     = 1000000;
  localparam int HOLD_AT   = 40;
  localparam int HOLD_LEN  = 700;
  localparam int DRAIN_AT  = 300;
  localparam int QUIET_LO  = 120;
  localparam int QUIET_HI  = 220;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_ready;
  slrw_pkg::item_t   item;
  logic              result_valid;
  logic              result_ready;
  slrw_pkg::result_t result;

  scrollback_line_ring_wrap i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  slrw_pkg::item_t   item_plan[$];
  slrw_pkg::result_t due_results[$];
  int      errors = 0;
  int      words_sent = 0;
  int      words_seen = 0;
  int      cycles = 0;

  // behavioral scrollback state
  bit         win_storage[NWIN];
  int         win_lines[NWIN];
  int         win_oldest[NWIN];
  bit         win_live[NWIN];
  int         win_view[NWIN];
  int         win_rows[NWIN];
  logic [7:0] line_mem[0:NWIN*NSLOTS*NBYTES-1];
  logic [7:0] stage[0:WRAP];
  int         stage_len;
  bit         cut_pending;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int view_top_of(int w);
    if (win_live[w]) return (win_lines[w] > NROWS) ? win_lines[w] - NROWS : 0;
    return win_view[w];
  endfunction

  function automatic slrw_pkg::result_t view_word(int w, logic [1:0] k);
    slrw_pkg::result_t r;
    r = '0;
    r.kind = k;
    r.is_live = win_live[w];
    r.view_top = 8'(view_top_of(w));
    r.line_count = 8'(win_lines[w]);
    return r;
  endfunction

  function automatic slrw_pkg::result_t file_line(int w, logic [7:0] txt[0:WRAP], int len,
                                                  bit show);
    slrw_pkg::result_t r;
    int slot, base;
    bit st, drw, scr;
    int drow;
    slot = 0; st = 0; drw = 0; scr = 0; drow = 0;
    if (win_storage[w]) begin
      if (win_lines[w] < NSLOTS) begin
        slot = (win_oldest[w] + win_lines[w]) % NSLOTS;
        win_lines[w]++;
      end else begin
        slot = win_oldest[w];
        win_oldest[w] = (slot + 1) % NSLOTS;
      end
      if (len > NBYTES - 1) len = NBYTES - 1;
      base = (w * NSLOTS + slot) * NBYTES;
      for (int k = 0; k < NBYTES; k++) line_mem[base + k] = (k < len) ? txt[k] : 8'd0;
      st = 1;
    end
    if (show && win_live[w]) begin
      drw = 1;
      if (win_rows[w] < NROWS) begin
        drow = win_rows[w];
        win_rows[w]++;
      end else begin
        scr = 1;
        drow = NROWS - 1;
      end
    end
    r = view_word(w, slrw_pkg::KIND_CHUNK);
    r.stored = st;
    r.slot_index = 8'(slot);
    r.draw_live = drw;
    r.scroll_first = scr;
    r.draw_row = 5'(drow);
    return r;
  endfunction

  function automatic void page_move(int w, bit up);
    int v;
    if (!win_storage[w] || win_lines[w] <= NROWS) return;
    v = win_live[w] ? win_lines[w] - NROWS : win_view[w];
    if (up) begin
      v -= NROWS - 1;
      if (v < 0) v = 0;
      win_view[w] = v;
      win_live[w] = 0;
    end else begin
      v += NROWS - 1;
      if (v >= win_lines[w] - NROWS) begin
        win_live[w] = 1;
        win_view[w] = 0;
      end else begin
        win_view[w] = v;
      end
    end
    win_rows[w] = NROWS;
  endfunction

  function automatic void scrollback_predict(slrw_pkg::item_t it);
    int w, li, slot, brk, skip, rest, len;
    logic [7:0] b;
    logic [7:0] chunk[0:WRAP];
    bit skipped;
    w = it.window;
    if (it.window >= slrw_pkg::WINDOWS_W4 || it.action > slrw_pkg::ACT_READ) return;
    case (it.action)
      slrw_pkg::ACT_OPEN: begin
        win_storage[w] = it.storage_ok;
        win_lines[w] = 0; win_oldest[w] = 0;
        win_live[w] = 1; win_view[w] = 0; win_rows[w] = 0;
        due_results.push_back(view_word(w, slrw_pkg::KIND_VIEW));
      end
      slrw_pkg::ACT_CLOSE: begin
        win_storage[w] = 0; win_lines[w] = 0; win_oldest[w] = 0;
        win_live[w] = 1; win_view[w] = 0;
      end
      slrw_pkg::ACT_CHAR: begin
        if (it.char_code == 8'd0) return;
        if (it.char_code == slrw_pkg::SPACE && cut_pending && stage_len == 0) return;
        if (stage_len > WRAP) stage_len = WRAP;
        stage[stage_len] = it.char_code;
        stage_len++;
        if (stage_len <= WRAP) return;
        brk = WRAP;
        while (brk > 0 && stage[brk] != slrw_pkg::SPACE) brk--;
        if (brk == 0) brk = WRAP;
        for (int k = 0; k <= WRAP; k++) chunk[k] = stage[k];
        skip = brk;
        while (skip <= WRAP && stage[skip] == slrw_pkg::SPACE) skip++;
        rest = WRAP + 1 - skip;
        for (int k = 0; k < rest; k++) stage[k] = stage[skip + k];
        stage_len = rest;
        cut_pending = 1;
        due_results.push_back(file_line(w, chunk, brk, it.show_live));
      end
      slrw_pkg::ACT_END: begin
        len = (stage_len > WRAP) ? WRAP : stage_len;
        skipped = (len == 0 && cut_pending);
        stage_len = 0;
        cut_pending = 0;
        if (!skipped) due_results.push_back(file_line(w, stage, len, it.show_live));
      end
      slrw_pkg::ACT_UP, slrw_pkg::ACT_DOWN: begin
        page_move(w, it.action == slrw_pkg::ACT_UP);
        due_results.push_back(view_word(w, slrw_pkg::KIND_VIEW));
      end
      default: begin
        li = view_top_of(w) + it.row;
        slot = 0;
        b = 8'd0;
        if (win_storage[w] && it.row < NROWS && li < win_lines[w]) begin
          slot = (win_oldest[w] + li) % NSLOTS;
          if (it.column < NBYTES - 1) b = line_mem[(w * NSLOTS + slot) * NBYTES + it.column];
        end
        due_results.push_back(view_word(w, slrw_pkg::KIND_READ));
        due_results[$].slot_index = 8'(slot);
        due_results[$].read_byte = b;
      end
    endcase
  endfunction

  function automatic slrw_pkg::item_t any_word();
    slrw_pkg::item_t it;
    it = slrw_pkg::item_t'({$urandom, $urandom});
    return it;
  endfunction

  function automatic slrw_pkg::item_t make_word(logic [2:0] act, int w);
    slrw_pkg::item_t it;
    it = any_word();
    it.action = act;
    it.window = 4'(w);
    return it;
  endfunction

  function automatic slrw_pkg::item_t text_word(int w, int space_pct);
    slrw_pkg::item_t it;
    it = make_word(slrw_pkg::ACT_CHAR, w);
    if ($urandom_range(99) < space_pct) it.char_code = slrw_pkg::SPACE;
    else it.char_code = 8'($urandom_range(1, 255));
    return it;
  endfunction

  function automatic int pick_gap(int n);
    int r;
    if (n >= QUIET_LO && n < QUIET_HI) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic push(slrw_pkg::item_t it);
    item_plan.push_back(it);
  endtask

  task automatic check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      errors++;
    end
  endtask

  // stimulus
  initial begin
    slrw_pkg::item_t it;
    int r, w, n;
    for (int i = 0; i < NWIN; i++) begin
      win_storage[i] = 0; win_lines[i] = 0; win_oldest[i] = 0;
      win_live[i] = 1; win_view[i] = 0; win_rows[i] = 0;
    end
    stage_len = 0;
    cut_pending = 0;

    it = make_word(slrw_pkg::ACT_OPEN, 0); it.storage_ok = 1; push(it);
    it = make_word(slrw_pkg::ACT_OPEN, 1); it.storage_ok = 0; push(it);
    it = make_word(slrw_pkg::ACT_OPEN, 10); it.storage_ok = 1; push(it);
    it = make_word(slrw_pkg::ACT_OPEN, 15); it.storage_ok = 1; push(it);
    it = make_word(slrw_pkg::ACT_READ, 0); it.row = 0; it.column = 0; push(it);
    it = make_word(slrw_pkg::ACT_END, 0); it.show_live = 1; push(it);
    it = make_word(slrw_pkg::ACT_CHAR, 0); it.char_code = 8'd255; push(it);
    it = make_word(slrw_pkg::ACT_CHAR, 0); it.char_code = 8'd1; push(it);
    it = make_word(slrw_pkg::ACT_CHAR, 0); it.char_code = 8'd0; push(it);
    it = make_word(slrw_pkg::ACT_CHAR, 0); it.char_code = slrw_pkg::SPACE; push(it);
    it = make_word(slrw_pkg::ACT_CHAR, 12); it.char_code = 8'd65; push(it);
    it = make_word(3'd7, 0); push(it);
    it = make_word(slrw_pkg::ACT_END, 0); it.show_live = 1; push(it);
    it = make_word(slrw_pkg::ACT_READ, 0); it.row = 1; it.column = 0; push(it);
    it = make_word(slrw_pkg::ACT_READ, 0); it.row = 1; it.column = 78; push(it);
    it = make_word(slrw_pkg::ACT_READ, 0); it.row = 1; it.column = 79; push(it);
    it = make_word(slrw_pkg::ACT_READ, 0); it.row = 1; it.column = 127; push(it);
    it = make_word(slrw_pkg::ACT_READ, 0); it.row = 31; it.column = 0; push(it);
    it = make_word(slrw_pkg::ACT_UP, 0); push(it);
    it = make_word(slrw_pkg::ACT_DOWN, 1); push(it);
    it = make_word(slrw_pkg::ACT_END, 1); it.show_live = 1; push(it);
    it = make_word(slrw_pkg::ACT_END, 10); it.show_live = 0; push(it);
    it = make_word(slrw_pkg::ACT_CLOSE, 10); push(it);
    it = make_word(slrw_pkg::ACT_READ, 10); it.row = 0; push(it);
    it = make_word(slrw_pkg::ACT_UP, 10); push(it);

    while (item_plan.size() < 540) begin
      r = $urandom_range(99);
      w = ($urandom_range(9) < 8) ? $urandom_range(0, 1) : $urandom_range(0, 15);
      if (r < 55) begin
        n = $urandom_range(0, 2);
        for (int k = 0; k < n; k++) push(text_word(w, 30));
        push(make_word(slrw_pkg::ACT_END, w));
      end else if (r < 63) begin
        n = $urandom_range(79, 170);
        for (int k = 0; k < n; k++) begin
          it = text_word(w, ($urandom_range(3) == 0) ? 0 : 15);
          if ($urandom_range(40) == 0) it.char_code = 8'd0;
          push(it);
        end
        push(make_word(slrw_pkg::ACT_END, w));
      end else if (r < 75) begin
        push(make_word($urandom_range(1) ? slrw_pkg::ACT_UP : slrw_pkg::ACT_DOWN, w));
      end else if (r < 88) begin
        it = make_word(slrw_pkg::ACT_READ, w);
        if ($urandom_range(4) != 0) begin
          it.row = 5'($urandom_range(0, 21));
          it.column = 7'($urandom_range(0, 80));
        end
        push(it);
      end else if (r < 91) begin
        it = make_word(slrw_pkg::ACT_OPEN, $urandom_range(1, 15));
        it.storage_ok = ($urandom_range(9) != 0);
        push(it);
      end else if (r < 93) begin
        push(make_word(slrw_pkg::ACT_CLOSE, $urandom_range(1, 15)));
      end else begin
        push(any_word());
      end
    end
  end

  // driver
  always @(posedge clk) begin : drive
    bit fire;
    int gap;
    if (rst) begin
      item_valid <= 1'b0;
      item <= '0;
      gap = 0;
    end else begin
      fire = item_valid && item_ready;
      if (fire) begin
        scrollback_predict(item);
        words_sent++;
      end
      if (item_valid && !fire) begin
        // hold the word until accepted
      end else if (gap > 0) begin
        gap--;
        item_valid <= 1'b0;
      end else if (item_plan.size() > 0 &&
                   !(words_sent == DRAIN_AT && due_results.size() != 0)) begin
        item <= item_plan.pop_front();
        item_valid <= 1'b1;
        gap = pick_gap(words_sent);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    int hold;
    int stall;
    bit held_once;
    slrw_pkg::result_t exp;
    if (rst) begin
      result_ready <= 1'b0;
      hold = 0;
      stall = 0;
      held_once = 0;
    end else begin
      if (result_valid && result_ready) begin
        words_seen++;
        if (due_results.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          exp = due_results.pop_front();
          check_field("kind", exp.kind, result.kind);
          check_field("stored", exp.stored, result.stored);
          check_field("slot_index", exp.slot_index, result.slot_index);
          check_field("draw_live", exp.draw_live, result.draw_live);
          check_field("scroll_first", exp.scroll_first, result.scroll_first);
          check_field("draw_row", exp.draw_row, result.draw_row);
          check_field("is_live", exp.is_live, result.is_live);
          check_field("view_top", exp.view_top, result.view_top);
          check_field("line_count", exp.line_count, result.line_count);
          check_field("read_byte", exp.read_byte, result.read_byte);
        end
      end
      if (!held_once && words_seen == HOLD_AT) begin
        held_once = 1;
        hold = HOLD_LEN;
      end
      if (hold > 0) begin
        hold--;
        result_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        result_ready <= 1'b0;
      end else begin
        stall = pick_gap(words_sent);
        result_ready <= (stall == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (item_plan.size() > 0 || item_valid) @(posedge clk);
    while (due_results.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (due_results.size() != 0) $error("%0d results never arrived", due_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
